/* hdl/ordered_list_table_unit_assert.svh */
// Assertion macros for the ordered list table unit.
// Included by the top level; no other dependencies.
`ifndef ORDERED_LIST_TABLE_UNIT_ASSERT_SVH
`define ORDERED_LIST_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OLT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olt: implication check failed");
`define OLT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olt: next-cycle check failed");
`else
`define OLT_ASSERT_IMP(label, clk, rst, ante, cons)
`define OLT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/olt_pkg.sv */
// Shared constants, codes and types for the ordered list table unit.
// No dependencies.
package olt_pkg;

  localparam int CAPACITY    = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam int TYPE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 6;
  localparam int LEN_W    = 7;

  typedef logic [TYPE_W-1:0]      req_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [ENTRY_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       count_t;

  localparam req_t REQ_APPEND = 3'd0;
  localparam req_t REQ_INSERT = 3'd1;
  localparam req_t REQ_DELETE = 3'd2;
  localparam req_t REQ_FIND   = 3'd3;
  localparam req_t REQ_SET    = 3'd4;
  localparam req_t REQ_GET    = 3'd5;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_RANGE     = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   read_value;
    logic [FOUND_W-1:0]   found_position;
    logic [LEN_W-1:0]     length;
  } result_t;

endpackage

/* hdl/ordered_list_table_unit.sv */
// Ordered list table unit: bounded list of words with append, insert, delete,
// find, set and get. Depends on olt_pkg, olt_ram, olt_ctrl, olt_out.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, position, item_value
//   out      output     out_valid / out_ready status, read_value, found_position, length
//
// One request at a time. Append, set, bad index and unused codes finish in S_EXEC;
// get adds a RAM read in S_GET. Find walks the entries, one RAM read a cycle.
// Insert and delete move each shifted entry through the single RAM write port.
// Reset clears the state and the count; the entry RAM needs no clearing.
// A stalled output holds one result while the next request is already taken in.
module ordered_list_table_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [olt_pkg::TYPE_W-1:0]   req_type,
  input  logic [olt_pkg::POS_W-1:0]    position,
  input  logic [olt_pkg::VALUE_W-1:0]  item_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [olt_pkg::STATUS_W-1:0] status,
  output logic [olt_pkg::VALUE_W-1:0]  read_value,
  output logic [olt_pkg::FOUND_W-1:0]  found_position,
  output logic [olt_pkg::LEN_W-1:0]    length
);
  import olt_pkg::*;

  mem_req_t mem;
  word_t    rdata;
  logic     res_valid;
  logic     res_take;
  result_t  res;

  olt_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ENTRY_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem.we),
    .waddr(mem.waddr),
    .wdata(mem.wdata),
    .raddr(mem.raddr),
    .rdata(rdata)
  );

  olt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .position  (position),
    .item_value(item_value),
    .mem       (mem),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  olt_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value),
    .found_position(found_position),
    .length        (length)
  );

`include "ordered_list_table_unit_assert.svh"

  `OLT_ASSERT_IMP(a_len_bound, clk, rst, out_valid, length <= LEN_W'(CAPACITY))
  `OLT_ASSERT_IMP(a_found_ok, clk, rst, out_valid && status != ST_OK, found_position == '0)
  `OLT_ASSERT_IMP(a_read_ok, clk, rst, out_valid && read_value != '0, status == ST_OK)
  `OLT_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

endmodule

/* hdl/olt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module olt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/olt_ctrl.sv */
// Request sequencer: decodes requests and walks the entry RAM for find and shifts.
// Depends on olt_pkg.
module olt_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  olt_pkg::req_t                   req_type,
  input  logic [olt_pkg::POS_W-1:0]       position,
  input  logic [olt_pkg::VALUE_W-1:0]     item_value,
  output olt_pkg::mem_req_t               mem,
  input  olt_pkg::word_t                  rdata,
  output logic                            res_valid,
  input  logic                            res_take,
  output olt_pkg::result_t                res
);
  import olt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FIND, S_INS, S_DEL, S_GET, S_RESULT
  } state_t;

  state_t             state;
  req_t               op;
  logic [POS_W-1:0]   pos;
  word_t              val;
  count_t             count;
  count_t             scan;
  logic               pend;
  addr_t              pend_idx;
  status_t            res_status;
  word_t              res_read;
  logic [FOUND_W-1:0] res_found;

  logic full;
  logic pos_le_count;
  logic pos_lt_count;
  logic hit;

  assign full         = count >= CNT_W'(CAPACITY);
  assign pos_le_count = pos <= POS_W'(count);
  assign pos_lt_count = pos < POS_W'(count);
  assign hit          = pend && (rdata == val);

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_RESULT;

  always_comb begin
    res.status         = res_status;
    res.read_value     = VALUE_W'(res_read);
    res.found_position = res_found;
    res.length         = LEN_W'(count);
  end

  always_comb begin
    mem.we    = 1'b0;
    mem.waddr = '0;
    mem.wdata = val;
    mem.raddr = '0;
    case (state)
      S_EXEC: begin
        case (op)
          REQ_APPEND: begin
            mem.we    = !full;
            mem.waddr = count[ADDR_W-1:0];
          end
          REQ_SET: begin
            mem.we    = pos_lt_count;
            mem.waddr = pos[ADDR_W-1:0];
          end
          REQ_GET: begin
            mem.raddr = pos[ADDR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      S_FIND: begin
        mem.raddr = scan[ADDR_W-1:0];
      end
      S_INS: begin
        mem.raddr = ADDR_W'(scan - 1'b1);
        if (pend) begin
          mem.we    = 1'b1;
          mem.waddr = pend_idx;
          mem.wdata = rdata;
        end else if (POS_W'(scan) == pos) begin
          mem.we    = 1'b1;
          mem.waddr = pos[ADDR_W-1:0];
        end
      end
      S_DEL: begin
        mem.raddr = scan[ADDR_W-1:0];
        if (pend) begin
          mem.we    = 1'b1;
          mem.waddr = pend_idx;
          mem.wdata = rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= req_type;
            pos   <= position;
            val   <= item_value[ENTRY_WIDTH-1:0];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= ST_OK;
          res_read   <= '0;
          res_found  <= '0;
          pend       <= 1'b0;
          state      <= S_RESULT;
          case (op)
            REQ_APPEND: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
              end
            end
            REQ_INSERT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else if (!pos_le_count) begin
                res_status <= ST_RANGE;
              end else begin
                scan  <= count;
                state <= S_INS;
              end
            end
            REQ_DELETE: begin
              if (!pos_lt_count) begin
                res_status <= ST_RANGE;
              end else begin
                scan  <= CNT_W'(pos) + 1'b1;
                state <= S_DEL;
              end
            end
            REQ_FIND: begin
              scan  <= '0;
              state <= S_FIND;
            end
            REQ_SET: begin
              if (!pos_lt_count) begin
                res_status <= ST_RANGE;
              end
            end
            REQ_GET: begin
              if (!pos_lt_count) begin
                res_status <= ST_RANGE;
              end else begin
                state <= S_GET;
              end
            end
            default: begin
            end
          endcase
        end
        S_GET: begin
          res_read <= rdata;
          state    <= S_RESULT;
        end
        S_FIND: begin
          if (hit) begin
            res_found <= FOUND_W'(pend_idx);
            state     <= S_RESULT;
          end else if (scan < count) begin
            pend     <= 1'b1;
            pend_idx <= scan[ADDR_W-1:0];
            scan     <= scan + 1'b1;
          end else begin
            res_status <= ST_NOT_FOUND;
            state      <= S_RESULT;
          end
        end
        S_INS: begin
          if (POS_W'(scan) > pos) begin
            pend     <= 1'b1;
            pend_idx <= scan[ADDR_W-1:0];
            scan     <= scan - 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count + 1'b1;
            state <= S_RESULT;
          end
        end
        S_DEL: begin
          if (scan < count) begin
            pend     <= 1'b1;
            pend_idx <= ADDR_W'(scan - 1'b1);
            scan     <= scan + 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            count <= count - 1'b1;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/olt_out.sv */
// Output register: holds one finished result until its transfer completes.
// Depends on olt_pkg.
module olt_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         res_valid,
  output logic                         res_take,
  input  olt_pkg::result_t             res,
  output logic                         out_valid,
  input  logic                         out_ready,
  output olt_pkg::status_t             status,
  output logic [olt_pkg::VALUE_W-1:0]  read_value,
  output logic [olt_pkg::FOUND_W-1:0]  found_position,
  output logic [olt_pkg::LEN_W-1:0]    length
);
  import olt_pkg::*;

  result_t held;

  assign res_take       = res_valid && (!out_valid || out_ready);
  assign status         = held.status;
  assign read_value     = held.read_value;
  assign found_position = held.found_position;
  assign length         = held.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      held <= res;
    end
  end

endmodule
